// ----- sv/gf2m_quadratic_solver_defines.svh -----
// Assertion macros shared by the solver's checker.
// No dependencies; included by bare file name.
`ifndef GF2M_QUADRATIC_SOLVER_DEFINES_SVH
`define GF2M_QUADRATIC_SOLVER_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define GQS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset
`define GQS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/gqs_pkg.sv -----
// Package for the GF(2^m) quadratic solver: widths, codes, shared types
// and the multiply-by-x step. No dependencies.
package gqs_pkg;

    localparam int ELEM_W     = 63;
    localparam int DEG_W      = 6;
    localparam int MAX_DEGREE = 63;
    localparam int CFG_IDX_W  = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FIELD_DEGREE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_TERMS    = 2'd1;

    // Reset values of the configuration registers
    localparam logic [DEG_W-1:0]  DEGREE_RST    = DEG_W'(63);
    localparam logic [ELEM_W-1:0] LOW_TERMS_RST = ELEM_W'(3);

    typedef enum logic [1:0] {
        STATUS_SOLVED  = 2'd0,
        STATUS_RETRY   = 2'd1,
        STATUS_NO_ROOT = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_WSQ,
        ST_ZSQ,
        ST_TMUL,
        ST_WTEST,
        ST_CHECK,
        ST_PUT
    } state_t;

    // Field description derived from the configuration registers
    typedef struct packed {
        logic [DEG_W-1:0]  m;
        logic [ELEM_W-1:0] mask;
        logic [ELEM_W-1:0] low;
    } field_t;

    // Request to the shared multiplier
    typedef struct packed {
        logic              start;
        logic [ELEM_W-1:0] a;
        logic [ELEM_W-1:0] b;
        logic [DEG_W-1:0]  len;
    } mul_req_t;

    // Response from the shared multiplier
    typedef struct packed {
        logic              done;
        logic [ELEM_W-1:0] product;
    } mul_rsp_t;

    // Build the field from degree and low terms; terms at or above x^m dropped
    function automatic field_t make_field(input logic [DEG_W-1:0] deg,
                                          input logic [ELEM_W-1:0] low_terms);
        field_t            f;
        logic [DEG_W-1:0]  m;
        logic [ELEM_W:0]   full;
        m = (int'(deg) > MAX_DEGREE) ? DEG_W'(MAX_DEGREE) : deg;
        full = ((ELEM_W+1)'(1) << m) - (ELEM_W+1)'(1);
        f.m    = m;
        f.mask = full[ELEM_W-1:0];
        f.low  = low_terms & full[ELEM_W-1:0];
        return f;
    endfunction

    // a * x mod f, a reduced
    function automatic logic [ELEM_W-1:0] mul_x(input logic [ELEM_W-1:0] a,
                                                input field_t f);
        logic [ELEM_W:0]   s;
        logic [ELEM_W-1:0] r;
        s = {a, 1'b0};
        r = s[ELEM_W-1:0] & f.mask;
        if (s[f.m])
            r = r ^ f.low;
        return r;
    endfunction

endpackage

// ----- sv/gqs_mul.sv -----
// Bit-serial GF(2^m) multiplier, one bit of the second operand per cycle,
// most significant first. Depends on gqs_pkg.
module gqs_mul (
    input  logic              clk,
    input  logic              rst_n,
    input  gqs_pkg::field_t   fld,
    input  gqs_pkg::mul_req_t req,
    output gqs_pkg::mul_rsp_t rsp
);
    import gqs_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DEG_W-1:0]  idx_reg, idx_next;
    logic [ELEM_W-1:0] acc_reg, acc_next;
    logic [ELEM_W-1:0] a_reg, a_next;
    logic [ELEM_W-1:0] b_reg, b_next;

    // Load on start, then shift-and-add down to bit zero
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        idx_next  = idx_reg;
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            idx_next  = req.len - DEG_W'(1);
            acc_next  = '0;
            a_next    = req.a;
            b_next    = req.b;
        end
        else if (busy_reg)
        begin
            acc_next = mul_x(acc_reg, fld) ^ (b_reg[idx_reg] ? a_reg : '0);
            idx_next = idx_reg - DEG_W'(1);
            if (idx_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
    end

    assign rsp.done    = done_reg;
    assign rsp.product = acc_reg;

endmodule

// ----- sv/gf2m_quadratic_solver.sv -----
// Solver for z^2 + z = b in GF(2^m), one shared bit-serial multiplier.
// Sequence (m >= 2): a 63-bit reduce, m-1 rounds of three m-bit multiplies and the
// final check multiply. A zero w skips the check. One word at a time: the next word is
// taken once the result is in the output register. Reset: m = 63, f = x^63 + x + 1, idle.
module gf2m_quadratic_solver (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic [gqs_pkg::ELEM_W-1:0]              value_b,
    input  logic [gqs_pkg::ELEM_W-1:0]              random_rho,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic [gqs_pkg::ELEM_W-1:0]              root,
    output logic [1:0]                              status,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [gqs_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [gqs_pkg::ELEM_W-1:0]              cfg_data
);
    import gqs_pkg::*;

    state_t            state_reg, state_next;
    logic              go_reg, go_next;
    logic              out_valid_reg, out_valid_next;
    logic [DEG_W-1:0]  degree_reg, degree_next;
    logic [ELEM_W-1:0] low_reg, low_next;

    logic [ELEM_W-1:0] b_reg, b_next;
    logic [ELEM_W-1:0] rho_reg, rho_next;
    logic [ELEM_W-1:0] br_reg, br_next;
    logic [ELEM_W-1:0] z_reg, z_next;
    logic [ELEM_W-1:0] w_reg, w_next;
    logic [ELEM_W-1:0] w2_reg, w2_next;
    logic [DEG_W-1:0]  round_reg, round_next;
    logic [ELEM_W-1:0] pend_root_reg, pend_root_next;
    status_t           pend_status_reg, pend_status_next;
    logic [ELEM_W-1:0] root_reg, root_next;
    status_t           status_reg, status_next;

    field_t            fld;
    mul_req_t          mreq;
    mul_rsp_t          mrsp;

    assign fld = make_field(degree_reg, low_reg);

    gqs_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .fld   (fld),
        .req   (mreq),
        .rsp   (mrsp)
    );

    // Configuration register decode
    always_comb
    begin
        degree_next = degree_reg;
        low_next    = low_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_FIELD_DEGREE: degree_next = cfg_data[DEG_W-1:0];
                CFG_LOW_TERMS:    low_next    = cfg_data;
                default:          ;
            endcase
        end
    end

    // Sequencer: next state, multiplier operands and datapath updates
    always_comb
    begin
        state_next       = state_reg;
        go_next          = 1'b0;
        out_valid_next   = out_valid_reg;
        b_next           = b_reg;
        rho_next         = rho_reg;
        br_next          = br_reg;
        z_next           = z_reg;
        w_next           = w_reg;
        w2_next          = w2_reg;
        round_next       = round_reg;
        pend_root_next   = pend_root_reg;
        pend_status_next = pend_status_reg;
        root_next        = root_reg;
        status_next      = status_reg;
        mreq.start       = go_reg;
        mreq.a           = z_reg;
        mreq.b           = z_reg;
        mreq.len         = fld.m;

        // output word taken
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    b_next     = value_b;
                    rho_next   = random_rho & fld.mask;
                    state_next = ST_REDUCE;
                    go_next    = 1'b1;
                end
            end
            ST_REDUCE:
            begin
                // b mod f as 1 * b over all bits
                mreq.a   = (fld.m == '0) ? '0 : ELEM_W'(1);
                mreq.b   = b_reg;
                mreq.len = DEG_W'(ELEM_W);
                if (mrsp.done)
                begin
                    br_next    = mrsp.product;
                    z_next     = '0;
                    w_next     = rho_reg;
                    round_next = DEG_W'(1);
                    if (fld.m >= DEG_W'(2))
                    begin
                        state_next = ST_WSQ;
                        go_next    = 1'b1;
                    end
                    else
                        state_next = ST_WTEST;
                end
            end
            ST_WSQ:
            begin
                mreq.a = w_reg;
                mreq.b = w_reg;
                if (mrsp.done)
                begin
                    w2_next    = mrsp.product;
                    state_next = ST_ZSQ;
                    go_next    = 1'b1;
                end
            end
            ST_ZSQ:
            begin
                if (mrsp.done)
                begin
                    z_next     = mrsp.product;
                    state_next = ST_TMUL;
                    go_next    = 1'b1;
                end
            end
            ST_TMUL:
            begin
                // z holds z^2 here; add w^2 * b
                mreq.a = w2_reg;
                mreq.b = br_reg;
                if (mrsp.done)
                begin
                    z_next     = z_reg ^ mrsp.product;
                    w_next     = w2_reg ^ rho_reg;
                    round_next = round_reg + DEG_W'(1);
                    if (round_reg == fld.m - DEG_W'(1))
                        state_next = ST_WTEST;
                    else
                    begin
                        state_next = ST_WSQ;
                        go_next    = 1'b1;
                    end
                end
            end
            ST_WTEST:
            begin
                if (w_reg == '0)
                begin
                    pend_root_next   = '0;
                    pend_status_next = STATUS_RETRY;
                    state_next       = ST_PUT;
                end
                else
                begin
                    state_next = ST_CHECK;
                    go_next    = 1'b1;
                end
            end
            ST_CHECK:
            begin
                // z^2 + z against b as given
                if (mrsp.done)
                begin
                    if ((mrsp.product ^ z_reg) != b_reg)
                    begin
                        pend_root_next   = '0;
                        pend_status_next = STATUS_NO_ROOT;
                    end
                    else
                    begin
                        pend_root_next   = z_reg;
                        pend_status_next = STATUS_SOLVED;
                    end
                    state_next = ST_PUT;
                end
            end
            ST_PUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    root_next      = pend_root_reg;
                    status_next    = pend_status_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Control and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            go_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            degree_reg    <= DEGREE_RST;
            low_reg       <= LOW_TERMS_RST;
        end
        else
        begin
            state_reg     <= state_next;
            go_reg        <= go_next;
            out_valid_reg <= out_valid_next;
            degree_reg    <= degree_next;
            low_reg       <= low_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        b_reg           <= b_next;
        rho_reg         <= rho_next;
        br_reg          <= br_next;
        z_reg           <= z_next;
        w_reg           <= w_next;
        w2_reg          <= w2_next;
        round_reg       <= round_next;
        pend_root_reg   <= pend_root_next;
        pend_status_reg <= pend_status_next;
        root_reg        <= root_next;
        status_reg      <= status_next;
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign root      = root_reg;
    assign status    = status_reg;
    assign cfg_ready = 1'b1;

endmodule

// ----- sv/gqs_checker.sv -----
// Port-level checks for the quadratic solver, bound to the top level.
// Depends on gqs_pkg and gf2m_quadratic_solver_defines.svh.
`include "gf2m_quadratic_solver_defines.svh"

module gqs_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_stall,
    input logic [gqs_pkg::ELEM_W-1:0]      value_b,
    input logic [gqs_pkg::ELEM_W-1:0]      random_rho,
    input logic                            out_valid,
    input logic                            out_stall,
    input logic [gqs_pkg::ELEM_W-1:0]      root,
    input logic [1:0]                      status,
    input logic                            cfg_valid,
    input logic                            cfg_ready,
    input logic [gqs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input logic [gqs_pkg::ELEM_W-1:0]      cfg_data
);
    import gqs_pkg::*;

    // A stalled result word holds
    `GQS_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(root) && $stable(status), "result word changed under stall")

    // Only the three defined status codes leave the block
    `GQS_ASSERT_IMP(a_status_code, clk, rst_n, out_valid, status == STATUS_SOLVED || status == STATUS_RETRY || status == STATUS_NO_ROOT, "undefined status code")

    // Failed attempts carry a zero root
    `GQS_ASSERT_IMP(a_fail_root, clk, rst_n, out_valid && status != STATUS_SOLVED, root == '0, "nonzero root on failure")

    // An accepted word keeps the block busy in the next cycle
    `GQS_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall, "input taken again without solving")

endmodule

bind gf2m_quadratic_solver gqs_checker u_gqs_checker (.*);

// ----- test/gqs_solution_checker.sv -----
// Checker for the GF(2^m) quadratic solver: tracks the field registers,
// predicts root and status per input word and compares results. Uses gqs_pkg.
`timescale 1ns / 100ps

module gqs_solution_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  logic [gqs_pkg::ELEM_W-1:0]     value_b,
    input  logic [gqs_pkg::ELEM_W-1:0]     random_rho,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  logic [gqs_pkg::ELEM_W-1:0]     root,
    input  logic [1:0]                     status,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [gqs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gqs_pkg::ELEM_W-1:0]     cfg_data,
    output int                             errors,
    output int                             pending
);
    import gqs_pkg::*;

    typedef struct {
        logic [ELEM_W-1:0] root;
        status_t           status;
    } solution_t;

    solution_t         solution_q[$];

    logic [DEG_W-1:0]  degree_reg;
    logic [ELEM_W-1:0] low_terms_reg;

    int                fld_m;
    logic [63:0]       fld_mask;
    logic [63:0]       fld_low;

    // field description seen by the predictor
    always_comb
    begin
        fld_m    = (int'(degree_reg) > MAX_DEGREE) ? MAX_DEGREE : int'(degree_reg);
        fld_mask = (64'd1 << fld_m) - 64'd1;
        fld_low  = {1'b0, low_terms_reg} & fld_mask;
    end

    // a * x mod f, a already reduced
    function automatic logic [63:0] fld_times_x(input logic [63:0] a);
        logic [63:0] s;
        s = a << 1;
        if (s[fld_m])
            s = (s & fld_mask) ^ fld_low;
        return s & fld_mask;
    endfunction

    // a * b mod f, a reduced, b any 63-bit polynomial (MSB first)
    function automatic logic [63:0] fld_mul(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] acc;
        int          i;
        acc = 64'd0;
        for (i = ELEM_W - 1; i >= 0; i--)
        begin
            acc = fld_times_x(acc);
            if (b[i])
                acc = acc ^ a;
        end
        return acc;
    endfunction

    // root and status for one word under the current field
    function automatic solution_t predict_solution(input logic [ELEM_W-1:0] b_in,
                                                   input logic [ELEM_W-1:0] rho_in);
        solution_t   sol;
        logic [63:0] b;
        logic [63:0] rho;
        logic [63:0] b_red;
        logic [63:0] z;
        logic [63:0] w;
        logic [63:0] w_sq;
        int          i;
        b     = {1'b0, b_in};
        rho   = {1'b0, rho_in} & fld_mask;
        b_red = fld_mul((fld_m == 0) ? 64'd0 : 64'd1, b);
        z     = 64'd0;
        w     = rho;
        for (i = 1; i < fld_m; i++)
        begin
            w_sq = fld_mul(w, w);
            z    = fld_mul(z, z) ^ fld_mul(w_sq, b_red);
            w    = w_sq ^ rho;
        end
        if (w == 64'd0)
        begin
            sol.root   = '0;
            sol.status = STATUS_RETRY;
        end
        else if ((fld_mul(z, z) ^ z) != b)
        begin
            // check uses b as given, so unreduced b has no root
            sol.root   = '0;
            sol.status = STATUS_NO_ROOT;
        end
        else
        begin
            sol.root   = z[ELEM_W-1:0];
            sol.status = STATUS_SOLVED;
        end
        return sol;
    endfunction

    // register shadow, prediction on input words, compare on output words
    always @(posedge clk or negedge rst_n)
    begin
        solution_t want;
        if (!rst_n)
        begin
            degree_reg    <= DEGREE_RST;
            low_terms_reg <= LOW_TERMS_RST;
            solution_q.delete();
            errors        <= 0;
            pending       <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_FIELD_DEGREE: degree_reg    <= cfg_data[DEG_W-1:0];
                    CFG_LOW_TERMS:    low_terms_reg <= cfg_data;
                    default:          ; // unused index, no effect
                endcase
            end

            if (in_valid && !in_stall)
                solution_q.push_back(predict_solution(value_b, random_rho));

            if (out_valid && !out_stall)
            begin
                if (solution_q.size() == 0)
                begin
                    if (errors < 10)
                        $display("unexpected word: root %h status %0d", root, status);
                    errors <= errors + 1;
                end
                else
                begin
                    want = solution_q.pop_front();
                    if (root !== want.root || status !== want.status)
                    begin
                        if (errors < 10)
                            $display("mismatch: root exp %h got %h, status exp %0d got %0d",
                                     want.root, root, want.status, status);
                        errors <= errors + 1;
                    end
                end
            end

            pending <= solution_q.size();
        end
    end

endmodule

// ----- test/gf2m_quadratic_solver_tb.sv -----
// Top of the quadratic solver testbench: clock, reset, stimulus, receiver
// stalls and verdict. Depends on gqs_pkg, the solver and gqs_solution_checker.
`timescale 1ns / 100ps

module gf2m_quadratic_solver_tb;

    import gqs_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 60000;
    localparam int HOLD_CYCLES    = 2000;
    localparam int DRAIN_CYCLES   = 13000;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [ELEM_W-1:0]     value_b = '0;
    logic [ELEM_W-1:0]     random_rho = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [ELEM_W-1:0]     root;
    logic [1:0]            status;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [ELEM_W-1:0]     cfg_data = '0;

    int                    errors;
    int                    pending;
    int                    idle_cycles = 0;
    bit                    hold_req = 1'b0;
    bit                    no_gaps = 1'b0;

    gf2m_quadratic_solver dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .value_b    (value_b),
        .random_rho (random_rho),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .root       (root),
        .status     (status),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    gqs_solution_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .value_b    (value_b),
        .random_rho (random_rho),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .root       (root),
        .status     (status),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .errors     (errors),
        .pending    (pending)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // watchdog: cycles with no word moving on any channel
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic logic [ELEM_W-1:0] rand_elem();
        logic [63:0] t;
        t = {$urandom, $urandom};
        return t[ELEM_W-1:0];
    endfunction

    // result side: random stall per word, plus one long hold-off on request
    initial
    begin
        int gap;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            gap = no_gaps ? 0 : $urandom_range(0, 8);
            if (gap > 0)
            begin
                out_stall <= 1'b1;
                repeat (gap) @(negedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!(out_valid && !out_stall));
        end
    end

    // offer one word after a random gap, return once it is taken
    task automatic send_word(input logic [ELEM_W-1:0] b, input logic [ELEM_W-1:0] rho);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 8);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        value_b    <= b;
        random_rho <= rho;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic drop_valid();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    // register write, only once every result is back
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [ELEM_W-1:0] data);
        while (pending != 0) @(negedge clk);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // degree with junk above bit 5; low terms optionally with junk at and above x^m
    task automatic set_field(input int m, input logic [ELEM_W-1:0] low, input bit junk_hi);
        logic [ELEM_W-1:0] junk;
        logic [63:0]       mask;
        junk = rand_elem();
        mask = (64'd1 << m) - 64'd1;
        cfg_write(CFG_FIELD_DEGREE, {junk[ELEM_W-1:DEG_W], DEG_W'(m)});
        if (junk_hi)
            low = low | (rand_elem() & ~mask[ELEM_W-1:0]);
        cfg_write(CFG_LOW_TERMS, low);
    endtask

    // mostly in-field b, some zero, all-ones and unreduced; rho rarely zero
    task automatic send_random(input int m);
        logic [63:0]       mask;
        logic [ELEM_W-1:0] b;
        logic [ELEM_W-1:0] rho;
        int                pick;
        mask = (64'd1 << m) - 64'd1;
        pick = $urandom_range(0, 9);
        case (pick)
            0:       b = '0;
            1:       b = rand_elem();
            2:       b = mask[ELEM_W-1:0];
            default: b = rand_elem() & mask[ELEM_W-1:0];
        endcase
        rho = ($urandom_range(0, 9) == 0) ? '0 : rand_elem();
        send_word(b, rho);
    endtask

    task automatic run_phase(input int m, input logic [ELEM_W-1:0] low, input int count,
                             input bit junk_hi, input bit hold, input bit quiet);
        set_field(m, low, junk_hi);
        no_gaps = quiet;
        if (hold)
            hold_req = 1'b1;
        repeat (count) send_random(m);
        drop_valid();
        no_gaps = 1'b0;
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset field x^63 + x + 1
        send_word('0, '1);
        send_word('1, '0);
        send_word(63'd1, 63'd1);
        send_word(rand_elem(), rand_elem());
        drop_valid();

        // m = 2, low terms all ones: bits at and above x^2 ignored
        set_field(2, '1, 1'b0);
        send_word(63'd0, 63'd1);
        send_word(63'd1, 63'd1);
        send_word(63'd2, 63'd2);
        send_word(63'd3, 63'd3);
        send_word(63'd1, 63'd0);
        send_word(63'd3, '1);
        send_word({1'b1, 62'd0}, 63'd1);
        drop_valid();

        // m = 1: no rounds, the zero-w test and the check decide
        set_field(1, 63'd1, 1'b0);
        send_word(63'd0, 63'd1);
        send_word(63'd1, 63'd1);
        send_word(63'd0, 63'd0);
        send_word('1, '1);
        drop_valid();

        // m = 0: every element zero
        set_field(0, 63'd0, 1'b0);
        send_word(63'd0, '1);
        send_word(rand_elem(), rand_elem());
        drop_valid();

        // write to an unused index
        cfg_write(CFG_UNUSED, rand_elem());

        // random phases over several fields, mostly small degrees
        run_phase(4,  63'h3,     20, 1'b0, 1'b1, 1'b0);
        run_phase(8,  63'h1B,    12, 1'b0, 1'b0, 1'b1);
        run_phase(5,  63'h5,     10, 1'b1, 1'b0, 1'b0);
        run_phase(2,  63'h3,     12, 1'b0, 1'b0, 1'b0);
        run_phase(13, rand_elem(), 10, 1'b0, 1'b0, 1'b0);
        run_phase(3,  63'h3,     10, 1'b1, 1'b0, 1'b0);
        run_phase(1,  rand_elem(), 8, 1'b0, 1'b0, 1'b0);
        run_phase(0,  rand_elem(), 5, 1'b0, 1'b0, 1'b0);
        run_phase(20, rand_elem(), 8, 1'b0, 1'b0, 1'b0);
        run_phase(7,  63'h3,     10, 1'b0, 1'b0, 1'b0);
        run_phase(6,  63'h0,      8, 1'b0, 1'b0, 1'b0);
        run_phase(10, '1,         8, 1'b0, 1'b0, 1'b0);
        run_phase(63, rand_elem(), 3, 1'b0, 1'b0, 1'b0);

        // drain, then allow for any stray late word
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+sv
sv/gqs_pkg.sv
sv/gqs_mul.sv
sv/gf2m_quadratic_solver.sv
sv/gqs_checker.sv
test/gqs_solution_checker.sv
test/gf2m_quadratic_solver_tb.sv
